// ===== rtl/lrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types, codes and helpers for the link reconnect backoff supervisor.
// ----------------------------------------------------------------------------
package lrb_pkg;

	localparam int OP_W    = 3;
	localparam int TS_W    = 3;
	localparam int CODE_W  = 3;
	localparam int ATT_W   = 9;
	localparam int TOTAL_W = 16;
	localparam int MAXA_W  = 8;
	localparam int DELAY_W = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [ATT_W-1:0]   SHIFT_LIMIT = ATT_W'(17);

	// register reset values
	localparam logic [MAXA_W-1:0]  MAX_ATTEMPTS_RST  = MAXA_W'(5);
	localparam logic [DELAY_W-1:0] BASE_DELAY_RST    = DELAY_W'(1000);
	localparam logic [DELAY_W-1:0] MAX_DELAY_RST     = DELAY_W'(30000);

	typedef enum logic [1:0] {
		REG_MAX_ATTEMPTS = 2'd0,
		REG_BASE_DELAY   = 2'd1,
		REG_MAX_DELAY    = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_EVENT      = 3'd0,
		OP_TICK       = 3'd1,
		OP_CONNECT    = 3'd2,
		OP_DISCONNECT = 3'd3,
		OP_REFUSED    = 3'd4
	} op_t;

	typedef enum logic [TS_W-1:0] {
		TS_DISCONNECTED = 3'd0,
		TS_CONNECTING   = 3'd1,
		TS_CONNECTED    = 3'd2,
		TS_READY        = 3'd3,
		TS_FAILED       = 3'd4
	} ts_t;

	// reported connection codes
	localparam logic [CODE_W-1:0] CODE_DISC         = 3'd0;
	localparam logic [CODE_W-1:0] CODE_CONNECTING   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_CONNECTED    = 3'd2;
	localparam logic [CODE_W-1:0] CODE_RECONNECTING = 3'd3;
	localparam logic [CODE_W-1:0] CODE_FAILED       = 3'd4;

	typedef enum logic [4:0] {
		LS_DISC         = 5'b00001,
		LS_CONNECTING   = 5'b00010,
		LS_CONNECTED    = 5'b00100,
		LS_RECONNECTING = 5'b01000,
		LS_FAILED       = 5'b10000
	} link_st_t;

	function automatic logic [CODE_W-1:0] link_code(input link_st_t st);
		logic [CODE_W-1:0] c;
		case (st)
			LS_DISC:         c = CODE_DISC;
			LS_CONNECTING:   c = CODE_CONNECTING;
			LS_CONNECTED:    c = CODE_CONNECTED;
			LS_RECONNECTING: c = CODE_RECONNECTING;
			LS_FAILED:       c = CODE_FAILED;
			default:         c = CODE_DISC;
		endcase
		return c;
	endfunction

	// min(base << attempt, cap); zero base gives zero
	function automatic logic [DELAY_W-1:0] backoff_delay(
		input logic [DELAY_W-1:0] base,
		input logic [DELAY_W-1:0] cap,
		input logic [ATT_W-1:0]   att
	);
		logic [2*DELAY_W-1:0] d;
		logic [DELAY_W-1:0]   r;
		d = {{DELAY_W{1'b0}}, base} << att[4:0];
		if (base == '0)
			r = '0;
		else if (att >= SHIFT_LIMIT)
			r = cap;
		else if (d >= {{DELAY_W{1'b0}}, cap})
			r = cap;
		else
			r = d[DELAY_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/lrb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_in_if
// Event channel: valid/ready with op, transport state and address check.
// ----------------------------------------------------------------------------
interface lrb_in_if;
	logic                        valid;
	logic                        ready;
	logic [lrb_pkg::OP_W-1:0]    op;
	logic [lrb_pkg::TS_W-1:0]    transport_state;
	logic                        url_ok;

	modport source (output valid, output op, output transport_state, output url_ok,
		input ready);
	modport sink (input valid, input op, input transport_state, input url_ok,
		output ready);
endinterface

// ===== rtl/lrb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_out_if
// Result channel: valid/ready with status, state, attempt and counters.
// ----------------------------------------------------------------------------
interface lrb_out_if;
	logic                          valid;
	logic                          ready;
	logic                          status_valid;
	logic [lrb_pkg::CODE_W-1:0]    conn_state;
	logic                          start_attempt;
	logic [lrb_pkg::ATT_W-1:0]     attempt_number;
	logic [lrb_pkg::TOTAL_W-1:0]   total_reconnects;

	modport source (output valid, output status_valid, output conn_state,
		output start_attempt, output attempt_number, output total_reconnects,
		input ready);
	modport sink (input valid, input status_valid, input conn_state,
		input start_attempt, input attempt_number, input total_reconnects,
		output ready);
endinterface

// ===== rtl/link_reconnect_backoff_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm
// Connection supervisor with capped exponential backoff between retries.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          op, transport_state, url_ok
//  out_ch    out  valid/ready          status_valid, conn_state, start_attempt,
//                                      attempt_number, total_reconnects
//  apb       in   psel/penable/pready  paddr[3:0], pwdata, prdata
//
//  The event register loads at the accepting edge; the result register loads
//  while it is empty or out_ch.ready is high, at one transaction per cycle.
//  The event register and the result register each hold one transaction;
//  a stalled result holds the event register, then in_ch.ready drops.
//  arst_n clears state, counters, valid flags and configuration registers to their defaults.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	lrb_in_if.sink                        in_ch,
	lrb_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrb_pkg::ADDR_W-1:0]    paddr,
	input  logic [lrb_pkg::DATA_W-1:0]    pwdata,
	output logic [lrb_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	// configuration
	logic [lrb_pkg::MAXA_W-1:0]  max_attempts_q;
	logic [lrb_pkg::DELAY_W-1:0] base_delay_q;
	logic [lrb_pkg::DELAY_W-1:0] max_delay_q;
	lrb_pkg::reg_idx_t           reg_idx;

	// event register
	logic                        s1_valid;
	logic [lrb_pkg::OP_W-1:0]    op_s1;
	logic [lrb_pkg::TS_W-1:0]    ts_s1;
	logic                        url_ok_s1;
	logic                        adv;

	// supervisor state
	lrb_pkg::link_st_t           link_q,      link_d;
	logic                        retrying_q,  retrying_d;
	logic                        stopped_q,   stopped_d;
	logic                        session_q,   session_d;
	logic                        held_q,      held_d;
	logic                        armed_q,     armed_d;
	logic [lrb_pkg::ATT_W-1:0]   att_q,       att_d;
	logic [lrb_pkg::TOTAL_W-1:0] total_q,     total_d;
	logic [lrb_pkg::DELAY_W-1:0] countdown_q, countdown_d;
	logic                        status_d;
	logic                        start_d;

	logic [lrb_pkg::DELAY_W-1:0] delay;
	logic [lrb_pkg::DELAY_W-1:0] cd_dec;
	logic [lrb_pkg::ATT_W-1:0]   att_inc;

	// result register
	logic                        out_valid_q;

	assign pready  = 1'b1;
	assign reg_idx = lrb_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (reg_idx)
			lrb_pkg::REG_MAX_ATTEMPTS: prdata = lrb_pkg::DATA_W'(max_attempts_q);
			lrb_pkg::REG_BASE_DELAY:   prdata = lrb_pkg::DATA_W'(base_delay_q);
			lrb_pkg::REG_MAX_DELAY:    prdata = lrb_pkg::DATA_W'(max_delay_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q <= lrb_pkg::MAX_ATTEMPTS_RST;
			base_delay_q   <= lrb_pkg::BASE_DELAY_RST;
			max_delay_q    <= lrb_pkg::MAX_DELAY_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				lrb_pkg::REG_MAX_ATTEMPTS: max_attempts_q <= pwdata[lrb_pkg::MAXA_W-1:0];
				lrb_pkg::REG_BASE_DELAY:   base_delay_q   <= pwdata[lrb_pkg::DELAY_W-1:0];
				lrb_pkg::REG_MAX_DELAY:    max_delay_q    <= pwdata[lrb_pkg::DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv         = s1_valid && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1     <= in_ch.op;
			ts_s1     <= in_ch.transport_state;
			url_ok_s1 <= in_ch.url_ok;
		end
	end

	assign delay   = lrb_pkg::backoff_delay(base_delay_q, max_delay_q, att_q);
	assign cd_dec  = (countdown_q != '0) ? countdown_q - 1'b1 : '0;
	assign att_inc = att_q + 1'b1;

	// next state
	always_comb begin
		link_d      = link_q;
		retrying_d  = retrying_q;
		stopped_d   = stopped_q;
		session_d   = session_q;
		held_d      = held_q;
		armed_d     = armed_q;
		att_d       = att_q;
		total_d     = total_q;
		countdown_d = countdown_q;
		status_d    = 1'b0;
		start_d     = 1'b0;
		case (op_s1)
			lrb_pkg::OP_EVENT: begin
				if (retrying_q) begin
					if (ts_s1 == lrb_pkg::TS_READY) begin
						retrying_d = 1'b0;
						att_d      = '0;
						armed_d    = 1'b0;
						link_d     = lrb_pkg::LS_CONNECTED;
						status_d   = 1'b1;
					end else if (ts_s1 == lrb_pkg::TS_FAILED) begin
						if (att_q < lrb_pkg::ATT_W'(max_attempts_q)) begin
							countdown_d = delay;
							armed_d     = 1'b1;
						end else begin
							retrying_d = 1'b0;
							armed_d    = 1'b0;
							link_d     = lrb_pkg::LS_FAILED;
							status_d   = 1'b1;
						end
					end
				end else begin
					case (ts_s1)
						lrb_pkg::TS_DISCONNECTED: begin
							link_d   = lrb_pkg::LS_DISC;
							status_d = 1'b1;
						end
						lrb_pkg::TS_CONNECTING, lrb_pkg::TS_CONNECTED: begin
							link_d   = lrb_pkg::LS_CONNECTING;
							status_d = 1'b1;
						end
						lrb_pkg::TS_READY: begin
							link_d   = lrb_pkg::LS_CONNECTED;
							att_d    = '0;
							status_d = 1'b1;
						end
						lrb_pkg::TS_FAILED: begin
							status_d = 1'b1;
							if (max_attempts_q != '0 && !stopped_q) begin
								retrying_d  = 1'b1;
								att_d       = '0;
								link_d      = lrb_pkg::LS_RECONNECTING;
								countdown_d = '0;
								armed_d     = 1'b1;
							end else begin
								link_d = lrb_pkg::LS_FAILED;
							end
						end
						default: ;
					endcase
				end
			end
			lrb_pkg::OP_TICK: begin
				if (session_q && retrying_q && armed_q) begin
					countdown_d = cd_dec;
					if (cd_dec == '0) begin
						att_d   = att_inc;
						armed_d = 1'b0;
						if (total_q != lrb_pkg::TOTAL_MAX)
							total_d = total_q + 1'b1;
						if (att_inc > lrb_pkg::ATT_W'(max_attempts_q)) begin
							retrying_d = 1'b0;
							link_d     = lrb_pkg::LS_FAILED;
							status_d   = 1'b1;
						end else begin
							held_d  = 1'b1;
							start_d = 1'b1;
						end
					end
				end
			end
			lrb_pkg::OP_CONNECT: begin
				if (link_q != lrb_pkg::LS_CONNECTING && link_q != lrb_pkg::LS_CONNECTED &&
					link_q != lrb_pkg::LS_RECONNECTING) begin
					if (!url_ok_s1) begin
						link_d   = lrb_pkg::LS_FAILED;
						status_d = 1'b1;
					end else begin
						stopped_d  = 1'b0;
						retrying_d = 1'b0;
						att_d      = '0;
						total_d    = '0;
						armed_d    = 1'b0;
						held_d     = 1'b1;
						session_d  = 1'b1;
						start_d    = 1'b1;
					end
				end
			end
			lrb_pkg::OP_DISCONNECT: begin
				if (!(link_q == lrb_pkg::LS_DISC && !session_q && !held_q)) begin
					stopped_d  = 1'b1;
					retrying_d = 1'b0;
					session_d  = 1'b0;
					held_d     = 1'b0;
					armed_d    = 1'b0;
					link_d     = lrb_pkg::LS_DISC;
					status_d   = 1'b1;
				end
			end
			lrb_pkg::OP_REFUSED: begin
				held_d = 1'b0;
				if (retrying_q) begin
					countdown_d = delay;
					armed_d     = 1'b1;
				end else begin
					armed_d   = 1'b0;
					session_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= lrb_pkg::LS_DISC;
			retrying_q  <= 1'b0;
			stopped_q   <= 1'b0;
			session_q   <= 1'b0;
			held_q      <= 1'b0;
			armed_q     <= 1'b0;
			att_q       <= '0;
			total_q     <= '0;
			countdown_q <= '0;
		end else if (adv) begin
			link_q      <= link_d;
			retrying_q  <= retrying_d;
			stopped_q   <= stopped_d;
			session_q   <= session_d;
			held_q      <= held_d;
			armed_q     <= armed_d;
			att_q       <= att_d;
			total_q     <= total_d;
			countdown_q <= countdown_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.status_valid     <= status_d;
			out_ch.conn_state       <= lrb_pkg::link_code(link_d);
			out_ch.start_attempt    <= start_d;
			out_ch.attempt_number   <= att_d;
			out_ch.total_reconnects <= total_d;
		end
	end

	assign out_ch.valid = out_valid_q;

	a_armed_only_retrying: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> retrying_q)
		else $error("retry timer armed outside reconnecting");

	a_retry_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		retrying_q == (link_q == lrb_pkg::LS_RECONNECTING))
		else $error("retrying flag and link state disagree");

	a_start_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_ch.start_attempt && out_ch.status_valid))
		else $error("attempt start reported together with status");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed transaction did not reach result register");

endmodule
